// File: sv/csvs_pkg.sv
// Shared types and constants for the class score vote smoother.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package csvs_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int HISTORY_LEN = 8;

   localparam int SCORE_W   = 8;
   localparam int HIST_BITS = $clog2(HISTORY_LEN);
   localparam int SUM_W     = SCORE_W + HIST_BITS;
   localparam int SLOT_W    = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int CLASS_W   = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
   localparam int TREE_SIZE = 2 ** CLASS_W;

   localparam int DIV_SHIFT = SUM_W + HIST_BITS + 1;
   localparam int RECIP     = (2 ** DIV_SHIFT + HISTORY_LEN - 1) / HISTORY_LEN;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int PROD_W    = SUM_W + RECIP_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef score_type [NUM_CLASSES-1:0] score_vec_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef sum_type [NUM_CLASSES-1:0] sum_vec_type;
   typedef logic [CLASS_W-1:0] class_type;
   typedef logic [PROD_W-1:0] prod_type;

endpackage

`default_nettype wire

// File: sv/csvs_front.sv
// Front stage: takes score vectors, keeps the ring history and running window sums.
// Depends on csvs_pkg; pushes updated sums into csvs_queue.
`default_nettype none

module csvs_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire csvs_pkg::score_vec_type req_scores,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output csvs_pkg::sum_vec_type       push_sums
);

   localparam logic [csvs_pkg::SLOT_W-1:0] LAST_SLOT =
      csvs_pkg::SLOT_W'(csvs_pkg::HISTORY_LEN - 1);

   csvs_pkg::score_type hist_ff [csvs_pkg::NUM_CLASSES][csvs_pkg::HISTORY_LEN];
   csvs_pkg::sum_vec_type sums_ff;
   csvs_pkg::sum_vec_type sums_in;
   logic [csvs_pkg::SLOT_W-1:0] slot_ff;
   logic [csvs_pkg::SLOT_W-1:0] slot_in;
   logic accept;

   always_comb begin
      accept = req_valid && push_ready;
      for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
         sums_in[c] = sums_ff[c] - csvs_pkg::SUM_W'(hist_ff[c][slot_ff])
                      + csvs_pkg::SUM_W'(req_scores[c]);
      end
      slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign push_sums  = sums_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
         slot_ff <= '0;
         for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
            for (int s = 0; s < csvs_pkg::HISTORY_LEN; s++) begin
               hist_ff[c][s] <= '0;
            end
         end
      end else if (accept) begin
         sums_ff <= sums_in;
         slot_ff <= slot_in;
         for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
            hist_ff[c][slot_ff] <= req_scores[c];
         end
      end
   end

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("Ring slot pointer left the history range.");

endmodule

`default_nettype wire

// File: sv/csvs_queue.sv
// Short queue of window sum vectors between the front and back stages.
// Depends on csvs_pkg for the entry type and depth.
`default_nettype none

module csvs_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire csvs_pkg::sum_vec_type  push_sums,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output csvs_pkg::sum_vec_type       pop_sums
);

   localparam logic [csvs_pkg::QPTR_W-1:0] LAST_PTR =
      csvs_pkg::QPTR_W'(csvs_pkg::QUEUE_DEPTH - 1);
   localparam logic [csvs_pkg::QCNT_W-1:0] FULL_COUNT =
      csvs_pkg::QCNT_W'(csvs_pkg::QUEUE_DEPTH);

   csvs_pkg::sum_vec_type mem_ff [csvs_pkg::QUEUE_DEPTH];
   logic [csvs_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [csvs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != FULL_COUNT);
      pop_valid  = (count_ff != '0);
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign pop_sums = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_sums;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("Queue fill count exceeds its depth.");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("Queue fill count missed a push.");

endmodule

`default_nettype wire

// File: sv/csvs_back.sv
// Back stage: divides window sums by the history length, picks the best class
// and compares it with the threshold. Depends on csvs_pkg.
`default_nettype none

module csvs_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire csvs_pkg::sum_vec_type  pop_sums,
   input  wire csvs_pkg::score_type    threshold,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output csvs_pkg::class_type         rsp_best_class,
   output csvs_pkg::score_type         rsp_best_average,
   output logic                        rsp_detected
);

   localparam int LVLS = csvs_pkg::CLASS_W;

   logic advance;
   logic s1_valid_ff;
   csvs_pkg::prod_type prod_ff [csvs_pkg::NUM_CLASSES];
   logic [csvs_pkg::NUM_CLASSES-1:0] neg_ff;
   logic [csvs_pkg::SUM_W-1:0] mag [csvs_pkg::NUM_CLASSES];

   csvs_pkg::score_type tree_val [LVLS+1][csvs_pkg::TREE_SIZE];
   csvs_pkg::class_type tree_idx [LVLS+1][csvs_pkg::TREE_SIZE];
   logic [csvs_pkg::SCORE_W-1:0] quot;

   logic rsp_valid_ff;
   csvs_pkg::class_type class_ff;
   csvs_pkg::score_type avg_ff;
   logic detected_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = advance;

   always_comb begin
      for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
         mag[c] = pop_sums[c][csvs_pkg::SUM_W-1] ? (~pop_sums[c] + 1'b1) : pop_sums[c];
      end
   end

   always_comb begin
      quot = '0;
      for (int l = 0; l <= LVLS; l++) begin
         for (int i = 0; i < csvs_pkg::TREE_SIZE; i++) begin
            tree_val[l][i] = '0;
            tree_idx[l][i] = '0;
         end
      end
      for (int i = 0; i < csvs_pkg::TREE_SIZE; i++) begin
         tree_idx[0][i] = csvs_pkg::CLASS_W'(i);
         if (i < csvs_pkg::NUM_CLASSES) begin
            quot = prod_ff[i][csvs_pkg::DIV_SHIFT +: csvs_pkg::SCORE_W];
            tree_val[0][i] = neg_ff[i] ? -quot : quot;
         end else begin
            tree_val[0][i] = {1'b1, {(csvs_pkg::SCORE_W-1){1'b0}}};
         end
      end
      for (int l = 0; l < LVLS; l++) begin
         for (int i = 0; i < (csvs_pkg::TREE_SIZE >> (l + 1)); i++) begin
            if (tree_val[l][2*i+1] > tree_val[l][2*i]) begin
               tree_val[l+1][i] = tree_val[l][2*i+1];
               tree_idx[l+1][i] = tree_idx[l][2*i+1];
            end else begin
               tree_val[l+1][i] = tree_val[l][2*i];
               tree_idx[l+1][i] = tree_idx[l][2*i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pop_valid) begin
         for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
            neg_ff[c]  <= pop_sums[c][csvs_pkg::SUM_W-1];
            prod_ff[c] <= csvs_pkg::PROD_W'(mag[c]) * csvs_pkg::PROD_W'(csvs_pkg::RECIP);
         end
      end
      if (advance && s1_valid_ff) begin
         class_ff    <= tree_idx[LVLS][0];
         avg_ff      <= tree_val[LVLS][0];
         detected_ff <= (tree_val[LVLS][0] > threshold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop_valid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_class   = class_ff;
   assign rsp_best_average = avg_ff;
   assign rsp_detected     = detected_ff;

   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff) |=> rsp_valid_ff)
      else $error("A divided sum vector did not reach the output register.");

   a_pop_to_stage: assert property (@(posedge clock) disable iff (reset)
      (advance && pop_valid) |=> s1_valid_ff)
      else $error("A popped sum vector was lost before the divide stage.");

endmodule

`default_nettype wire

// File: sv/class_score_vote_smoother_top.sv
// Top level of the class score vote smoother: threshold register, front, queue, back.
// Path: an accepted input goes into the queue, then the divide and output registers.
// Throughput: one item per cycle while the queue has room, set by the front's sum update.
// Reset: synchronous, clears history, window sums, ring slot, queue and threshold to zero.
// Depends on csvs_pkg, csvs_front, csvs_queue and csvs_back.
`default_nettype none

module class_score_vote_smoother_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire csvs_pkg::score_type  req_score_0,
   input  wire csvs_pkg::score_type  req_score_1,
   input  wire csvs_pkg::score_type  req_score_2,
   input  wire csvs_pkg::score_type  req_score_3,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output csvs_pkg::class_type       rsp_best_class,
   output csvs_pkg::score_type       rsp_best_average,
   output logic                      rsp_detected,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire csvs_pkg::score_type  csr_wdata
);

   csvs_pkg::score_type threshold_ff;
   csvs_pkg::score_vec_type scores;
   csvs_pkg::sum_vec_type push_sums, pop_sums;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign scores    = {req_score_3, req_score_2, req_score_1, req_score_0};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_valid) begin
         threshold_ff <= csr_wdata;
      end
   end

   csvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_scores (scores),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sums  (push_sums)
   );

   csvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sums  (push_sums),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_sums   (pop_sums)
   );

   csvs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_sums         (pop_sums),
      .threshold        (threshold_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_best_class   (rsp_best_class),
      .rsp_best_average (rsp_best_average),
      .rsp_detected     (rsp_detected)
   );

endmodule

`default_nettype wire

// File: bench/class_score_vote_smoother_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the class score vote smoother: watches the score, vote and threshold
// channels, predicts each vote from its own window history and compares field by field.
// Depends on csvs_pkg.
module class_score_vote_smoother_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  csvs_pkg::score_type req_score_0,
   input  csvs_pkg::score_type req_score_1,
   input  csvs_pkg::score_type req_score_2,
   input  csvs_pkg::score_type req_score_3,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  csvs_pkg::class_type rsp_best_class,
   input  csvs_pkg::score_type rsp_best_average,
   input  logic                rsp_detected,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  csvs_pkg::score_type csr_wdata,
   output int                  error_count,
   output int                  pending_count
);

   typedef struct packed {
      csvs_pkg::class_type best_class;
      csvs_pkg::score_type best_average;
      logic                detected;
   } vote_type;

   vote_type            expected_votes[$];
   csvs_pkg::score_type window_hist[csvs_pkg::NUM_CLASSES][csvs_pkg::HISTORY_LEN];
   int                  class_sum[csvs_pkg::NUM_CLASSES];
   int                  next_slot;
   csvs_pkg::score_type threshold;
   int                  errors;

   task automatic clear_history();
      for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
         class_sum[c] = 0;
         for (int k = 0; k < csvs_pkg::HISTORY_LEN; k++) begin
            window_hist[c][k] = '0;
         end
      end
      next_slot = 0;
      threshold = '0;
   endtask

   task automatic absorb_scores(input csvs_pkg::score_vec_type scores, output vote_type vote);
      csvs_pkg::score_type s;
      int                  avg;
      int                  best_avg;
      int                  best;
      best_avg = 0;
      best = 0;
      for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
         s = scores[c];
         class_sum[c] = class_sum[c] - int'(window_hist[c][next_slot]) + int'(s);
         window_hist[c][next_slot] = s;
      end
      next_slot = (next_slot + 1 >= csvs_pkg::HISTORY_LEN) ? 0 : next_slot + 1;
      for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
         avg = class_sum[c] / csvs_pkg::HISTORY_LEN;
         if (c == 0 || avg > best_avg) begin
            best = c;
            best_avg = avg;
         end
      end
      vote.best_class = csvs_pkg::class_type'(best);
      vote.best_average = csvs_pkg::score_type'(best_avg);
      vote.detected = (best_avg > int'(threshold));
   endtask

   initial begin
      errors = 0;
      clear_history();
   end

   always @(posedge clock) begin
      vote_type got;
      vote_type want;
      vote_type fresh;
      if (reset) begin
         clear_history();
         expected_votes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_best_class, rsp_best_average, rsp_detected};
            if (expected_votes.size() == 0) begin
               if (errors < 10) begin
                  $display("unexpected vote transfer: class %0d avg %0d det %0b",
                           got.best_class, got.best_average, got.detected);
               end
               errors++;
            end else begin
               want = expected_votes.pop_front();
               if (got.best_class !== want.best_class ||
                   got.best_average !== want.best_average ||
                   got.detected !== want.detected) begin
                  if (errors < 10) begin
                     $display({"vote mismatch: expected class %0d avg %0d det %0b, ",
                               "got class %0d avg %0d det %0b"},
                              want.best_class, want.best_average, want.detected,
                              got.best_class, got.best_average, got.detected);
                  end
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_scores({req_score_3, req_score_2, req_score_1, req_score_0}, fresh);
            expected_votes.push_back(fresh);
         end
         if (csr_valid && csr_ready) begin
            threshold = csr_wdata;
         end
      end
      error_count <= errors;
      pending_count <= expected_votes.size();
   end

endmodule

// File: bench/class_score_vote_smoother_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the class score vote smoother: drives scores and threshold writes
// with random bursts and stalls, and reports the verdict from the checker's counts.
// Depends on csvs_pkg, class_score_vote_smoother_top and class_score_vote_smoother_checker.
module class_score_vote_smoother_top_tb;

   localparam int CYCLE_LIMIT = 200000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   csvs_pkg::score_type req_score_0 = '0;
   csvs_pkg::score_type req_score_1 = '0;
   csvs_pkg::score_type req_score_2 = '0;
   csvs_pkg::score_type req_score_3 = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b1;
   csvs_pkg::class_type rsp_best_class;
   csvs_pkg::score_type rsp_best_average;
   logic                rsp_detected;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csvs_pkg::score_type csr_wdata = '0;
   int                  error_count;
   int                  pending_count;
   int                  stall_pct = 0;
   int                  stall_left = 0;

   class_score_vote_smoother_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_score_0      (req_score_0),
      .req_score_1      (req_score_1),
      .req_score_2      (req_score_2),
      .req_score_3      (req_score_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_best_class   (rsp_best_class),
      .rsp_best_average (rsp_best_average),
      .rsp_detected     (rsp_detected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   class_score_vote_smoother_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_score_0      (req_score_0),
      .req_score_1      (req_score_1),
      .req_score_2      (req_score_2),
      .req_score_3      (req_score_3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_best_class   (rsp_best_class),
      .rsp_best_average (rsp_best_average),
      .rsp_detected     (rsp_detected),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(7);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_scores(input csvs_pkg::score_type s0, s1, s2, s3);
      @(negedge clock);
      req_valid = 1'b1;
      req_score_0 = s0;
      req_score_1 = s1;
      req_score_2 = s2;
      req_score_3 = s3;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_votes();
      pause_sender(0);
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_threshold(input csvs_pkg::score_type value);
      drain_votes();
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic csvs_pkg::score_type pick_score(input int kind, input bit favored);
      case (kind)
         4, 5: begin
            case ($urandom_range(3))
               0: return csvs_pkg::score_type'(-128);
               1: return csvs_pkg::score_type'(127);
               2: return csvs_pkg::score_type'(-1);
               default: return csvs_pkg::score_type'(0);
            endcase
         end
         6, 7: begin
            if (favored) return csvs_pkg::score_type'($urandom_range(100, 127));
            return csvs_pkg::score_type'($urandom);
         end
         9: return csvs_pkg::score_type'(int'($urandom_range(16)) - 8);
         default: return csvs_pkg::score_type'($urandom);
      endcase
   endfunction

   task automatic run_random(input int count, input bit gaps);
      int                  burst_left;
      int                  kind;
      int                  lead;
      csvs_pkg::score_type s[csvs_pkg::NUM_CLASSES];
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (gaps && burst_left == 0) begin
            pause_sender($urandom_range(1, 6));
            if ($urandom_range(19) == 0) drain_votes();
            burst_left = $urandom_range(1, 12);
         end
         kind = $urandom_range(9);
         lead = $urandom_range(csvs_pkg::NUM_CLASSES - 1);
         for (int c = 0; c < csvs_pkg::NUM_CLASSES; c++) begin
            s[c] = pick_score(kind, c == lead);
         end
         if (kind == 8) begin
            for (int c = 1; c < csvs_pkg::NUM_CLASSES; c++) s[c] = s[0];
         end
         send_scores(s[0], s[1], s[2], s[3]);
         if (burst_left > 0) burst_left--;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_scores(8'sd0, 8'sd0, 8'sd127, 8'sd0);
      send_scores(-8'sd1, -8'sd2, -8'sd3, -8'sd4);
      repeat (8) send_scores(-8'sd128, 8'sd127, 8'sd127, 8'sd0);
      write_threshold(8'sd127);
      send_scores(-8'sd128, 8'sd127, 8'sd127, 8'sd0);
      repeat (8) send_scores(-8'sd128, -8'sd128, -8'sd128, -8'sd128);
      write_threshold(-8'sd128);
      send_scores(-8'sd128, -8'sd128, -8'sd128, -8'sd128);

      write_threshold(8'sd127);
      stall_pct = 0;
      run_random(80, 1'b0);
      write_threshold(-8'sd128);
      stall_pct = 30;
      run_random(80, 1'b1);
      write_threshold(8'sd0);
      stall_pct = 0;
      run_random(80, 1'b1);
      write_threshold(csvs_pkg::score_type'($urandom));
      stall_pct = 50;
      run_random(80, 1'b0);
      write_threshold(csvs_pkg::score_type'($urandom_range(0, 40)));
      stall_pct = 20;
      run_random(80, 1'b1);

      drain_votes();
      stall_pct = 0;
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: class_score_vote_smoother_top.f
sv/csvs_pkg.sv
sv/csvs_front.sv
sv/csvs_queue.sv
sv/csvs_back.sv
sv/class_score_vote_smoother_top.sv
bench/class_score_vote_smoother_checker.sv
bench/class_score_vote_smoother_top_tb.sv
